[rtl/core/shpba_pkg.sv]
// ----------------------------------------------------------------------------
// Shaper pulse bin accumulator package
// Shared widths, configuration and item types, state codes and the e^-x table.
// ----------------------------------------------------------------------------
package shpba_pkg;

	localparam int CHARGE_W   = 24;
	localparam int TIME_W     = 16;
	localparam int VAL_W      = 48;
	localparam int IDX_W      = 4;
	localparam int NB_W       = 5;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;
	localparam int TDATA_W    = 56;
	localparam int TC_W       = 23;
	localparam int DIV_W      = 39;
	localparam int X_W        = 21;
	localparam int KVAL_W     = 33;
	localparam int NORM_W     = 24;
	localparam int EXP_N      = 256;
	localparam int EXP_AW     = $clog2(EXP_N);
	localparam int EXP_VW     = 31;

	localparam logic [16:0] LOG2E_Q16    = 17'd94548;
	localparam logic [16:0] NORM_CENTRAL = 17'd48753;
	localparam logic [16:0] NORM_NEIGH   = 17'd83633;
	localparam logic [16:0] ONE_Q16      = 17'd65536;
	localparam logic [20:0] THREE_Q16    = 21'd196608;
	localparam logic [63:0] LN2_Q32      = 64'd2977044472;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MODE        = 3'd0,
		REG_PEAK_TIME   = 3'd1,
		REG_NUM_BINS    = 3'd2,
		REG_BIN_SPACING = 3'd3,
		REG_CROSS_TWO   = 3'd4,
		REG_CROSS_BACK  = 3'd5
	} cfg_reg_t;

	typedef struct packed {
		logic        mode;
		logic [15:0] peak_time;
		logic [4:0]  num_bins;
		logic [15:0] bin_spacing;
		logic [15:0] cross_two_sides;
		logic [15:0] cross_back;
	} cfg_t;

	typedef struct packed {
		logic signed [CHARGE_W-1:0] charge;
		logic signed [TIME_W-1:0]   arrival;
		logic signed [TIME_W-1:0]   threshold;
		logic                       group_end;
		logic [NB_W-1:0]            nb;
	} item_t;

	typedef enum logic [2:0] {
		KS_IDLE,
		KS_DIV,
		KS_EXP,
		KS_CUBE,
		KS_PROD,
		KS_DERIV,
		KS_FINAL
	} kern_state_t;

	typedef enum logic [3:0] {
		BS_IDLE,
		BS_BIN,
		BS_KWAIT,
		BS_ACC,
		BS_NORM1,
		BS_NORM2,
		BS_ERD,
		BS_EMUL,
		BS_EOUT
	} back_state_t;

	typedef logic [EXP_N-1:0][EXP_VW-1:0] exp_tab_t;

	// 2^-(j/N) in Q30 from a Taylor series of e^-a
	function automatic exp_tab_t build_exp_tab();
		exp_tab_t           tab;
		logic [63:0]        a;
		logic [127:0]       prod;
		logic [63:0]        term;
		logic signed [65:0] sum;
		logic [65:0]        rnd;
		for (int j = 0; j < EXP_N; j++) begin
			a = (64'(j) * LN2_Q32) / 64'(EXP_N);
			term = 64'd1 << 32;
			sum = $signed({2'b00, term});
			for (int k = 1; k <= 24; k++) begin
				prod = {64'd0, term} * {64'd0, a};
				term = prod[95:32] / 64'(k);
				if ((k & 1) != 0) begin
					sum = sum - $signed({2'b00, term});
				end else begin
					sum = sum + $signed({2'b00, term});
				end
			end
			if (sum < 0) begin
				sum = '0;
			end
			rnd = (unsigned'(sum) + 66'd2) >> 2;
			tab[j] = rnd[EXP_VW-1:0];
		end
		return tab;
	endfunction

	localparam exp_tab_t EXP_TAB = build_exp_tab();

endpackage

[rtl/core/shpba_ram.sv]
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module shpba_ram #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 16,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

[rtl/core/shpba_fifo.sv]
// ----------------------------------------------------------------------------
// Item queue
// Short FIFO between the front and the back part.
// ----------------------------------------------------------------------------
module shpba_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] din,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] dout,
	output logic             valid
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wptr_q, rptr_q;
	logic [CW-1:0]    cnt_q;

	assign full  = (cnt_q == CW'(DEPTH));
	assign valid = (cnt_q != '0);
	assign dout  = mem_q[rptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (push) begin
				wptr_q <= (wptr_q == AW'(DEPTH - 1)) ? '0 : wptr_q + AW'(1);
			end
			if (pop) begin
				rptr_q <= (rptr_q == AW'(DEPTH - 1)) ? '0 : rptr_q + AW'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wptr_q] <= din;
		end
	end

endmodule

[rtl/core/shpba_front.sv]
// ----------------------------------------------------------------------------
// Front part
// Accepts charge beats, tracks the open group and its threshold, clamps the
// bin count and pushes one work item into the queue.
// ----------------------------------------------------------------------------
module shpba_front #(
	parameter int MAX_BINS = 16
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_axis_tvalid,
	output logic                               s_axis_tready,
	input  logic [shpba_pkg::TDATA_W-1:0]      s_axis_tdata,
	input  logic                               s_axis_tlast,
	input  logic [shpba_pkg::NB_W-1:0]         num_bins,
	output logic                               push,
	output shpba_pkg::item_t                   push_item,
	input  logic                               full
);

	import shpba_pkg::*;

	logic                     group_open_q;
	logic signed [TIME_W-1:0] thr_q;
	logic signed [TIME_W-1:0] in_thr;
	logic [NB_W-1:0]          nb;

	assign s_axis_tready = !full;
	assign push          = s_axis_tvalid && !full;
	assign in_thr        = s_axis_tdata[55:40];

	always_comb begin
		if (num_bins == '0) begin
			nb = NB_W'(1);
		end else if (int'(num_bins) > MAX_BINS) begin
			nb = NB_W'(MAX_BINS);
		end else begin
			nb = num_bins;
		end
	end

	always_comb begin
		push_item.charge    = s_axis_tdata[23:0];
		push_item.arrival   = s_axis_tdata[39:24];
		push_item.threshold = group_open_q ? thr_q : in_thr;
		push_item.group_end = s_axis_tlast;
		push_item.nb        = nb;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			group_open_q <= 1'b0;
			thr_q        <= '0;
		end else if (push) begin
			if (!group_open_q) begin
				thr_q <= in_thr;
			end
			group_open_q <= !s_axis_tlast;
		end
	end

endmodule

[rtl/core/shpba_kernel.sv]
// ----------------------------------------------------------------------------
// Shaper kernel unit
// Restoring divide for x = 3*tc/peak_time in Q16, then e^-x from the table
// and the x^3 e^-x or x^2 e^-x (3-x) product.
// ----------------------------------------------------------------------------
module shpba_kernel (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	input  logic [shpba_pkg::TC_W-2:0]          tc,
	input  logic                                mode,
	input  logic [15:0]                         peak_time,
	output logic                                done,
	output logic signed [shpba_pkg::KVAL_W-1:0] kval
);

	import shpba_pkg::*;

	kern_state_t state_q, state_d;

	logic [DIV_W-1:0] dvd_q, quo_q;
	logic [15:0]      rem_q;
	logic [5:0]       cnt_q;
	logic [15:0]      pt;
	logic [16:0]      rem_sh;
	logic             fits;
	logic [23:0]      tc3;

	logic [X_W-1:0]   x_q;
	logic             zero_q;
	logic [37:0]      y_q;
	logic [41:0]      x2f_q;
	logic [25:0]      x2_q;
	logic [46:0]      x3f_q;
	logic [EXP_VW-1:0] e_q;
	logic [61:0]      pr_q;
	logic [47:0]      pr2_q;
	logic             dneg_q;
	logic             dneg;
	logic [X_W-1:0]   ad;
	logic [KVAL_W-1:0] mag;

	assign pt     = (peak_time == '0) ? 16'd1 : peak_time;
	assign rem_sh = {rem_q, dvd_q[DIV_W-1]};
	assign fits   = (rem_sh >= {1'b0, pt});
	assign tc3    = {1'b0, tc, 1'b0} + {2'b00, tc};
	assign dneg   = (x_q > THREE_Q16);
	assign ad     = dneg ? (x_q - THREE_Q16) : (THREE_Q16 - x_q);
	assign mag    = {1'b0, pr2_q[47:16]};

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			KS_IDLE:  if (start) state_d = KS_DIV;
			KS_DIV:   if (cnt_q == 6'd1) state_d = KS_EXP;
			KS_EXP:   state_d = KS_CUBE;
			KS_CUBE:  state_d = KS_PROD;
			KS_PROD:  state_d = KS_DERIV;
			KS_DERIV: state_d = KS_FINAL;
			KS_FINAL: state_d = KS_IDLE;
			default:  state_d = KS_IDLE;
		endcase
	end

	always_comb begin
		done = (state_q == KS_FINAL);
		if (zero_q) begin
			kval = '0;
		end else if (dneg_q) begin
			kval = -$signed(mag);
		end else begin
			kval = $signed(mag);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= KS_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			KS_IDLE: begin
				if (start) begin
					dvd_q <= {tc3[22:0], 16'd0};
					rem_q <= '0;
					quo_q <= '0;
					cnt_q <= 6'(DIV_W);
				end
			end
			KS_DIV: begin
				dvd_q <= {dvd_q[DIV_W-2:0], 1'b0};
				rem_q <= fits ? 16'(rem_sh - {1'b0, pt}) : rem_sh[15:0];
				quo_q <= {quo_q[DIV_W-2:0], fits};
				cnt_q <= cnt_q - 6'd1;
			end
			KS_EXP: begin
				x_q    <= quo_q[X_W-1:0];
				zero_q <= |quo_q[DIV_W-1:X_W];
				y_q    <= 38'(quo_q[X_W-1:0]) * 38'(LOG2E_Q16);
				x2f_q  <= 42'(quo_q[X_W-1:0]) * 42'(quo_q[X_W-1:0]);
			end
			KS_CUBE: begin
				zero_q <= zero_q || (y_q[37:32] >= 6'd31);
				e_q    <= EXP_TAB[y_q[31 -: EXP_AW]] >> y_q[36:32];
				x2_q   <= x2f_q[41:16];
				x3f_q  <= 47'(x2f_q[41:16]) * 47'(x_q);
			end
			KS_PROD: begin
				pr_q <= 62'(mode ? 31'(x2_q) : x3f_q[46:16]) * 62'(e_q);
			end
			KS_DERIV: begin
				if (mode) begin
					pr2_q  <= 48'(pr_q[56:30]) * 48'(ad);
					dneg_q <= dneg;
				end else begin
					pr2_q  <= {pr_q[61:30], 16'd0};
					dneg_q <= 1'b0;
				end
			end
			KS_FINAL: begin
			end
			default: begin
			end
		endcase
	end

endmodule

[rtl/core/shpba_back.sv]
// ----------------------------------------------------------------------------
// Back part
// Walks the bins of each queued item, adds charge times kernel to the bin
// store, and on a group end scales and emits the used bins and clears all.
// ----------------------------------------------------------------------------
module shpba_back #(
	parameter int MAX_BINS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  shpba_pkg::cfg_t               cfg,
	input  logic                          q_valid,
	input  shpba_pkg::item_t              q_item,
	output logic                          q_pop,
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	output logic [shpba_pkg::TDATA_W-1:0] m_axis_tdata,
	output logic                          m_axis_tlast
);

	import shpba_pkg::*;

	localparam int AW = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
	localparam logic signed [VAL_W-1:0] MAX48 = {1'b0, {(VAL_W-1){1'b1}}};
	localparam logic signed [VAL_W-1:0] MIN48 = {1'b1, {(VAL_W-1){1'b0}}};
	localparam logic [48:0] CAP48 = 49'h0_8000_0000_0000;

	back_state_t state_q, state_d;

	item_t                     item_q;
	logic [NB_W-1:0]           k_q;
	logic signed [TC_W-1:0]    off_q;
	logic signed [TC_W-1:0]    tc_full;
	logic signed [TC_W-1:0]    sp;
	logic                      tc_pos;
	logic [AW+NB_W-1:0]        kext;
	logic [AW-1:0]             addr;
	logic                      last_bin;
	logic                      out_free;

	logic                      kstart, kdone;
	logic signed [KVAL_W-1:0]  kval;
	logic                      ram_re, ram_we;
	logic [VAL_W-1:0]          rdata;
	logic signed [VAL_W-1:0]   base;
	logic signed [VAL_W-1:0]   acc_sat;
	logic [MAX_BINS-1:0]       vld_q;
	logic                      vbit_q;

	logic signed [56:0]        c_q;
	logic [56:0]               cmag;
	logic signed [49:0]        qs;
	logic signed [50:0]        sum;

	logic [33:0]               m1_q;
	logic [50:0]               m2;
	logic [16:0]               fac1, fac2;
	logic [NORM_W-1:0]         norm_q;
	logic                      neg_q;
	logic [VAL_W-1:0]          amag;
	logic [47:0]               ph_q, pl_q;
	logic [48:0]               r, rc;
	logic [VAL_W-1:0]          oval;
	logic                      load;

	logic                      ovalid_q;
	logic [VAL_W-1:0]          odata_q;
	logic [IDX_W-1:0]          oidx_q;
	logic                      olast_q;

	assign sp       = TC_W'($signed({1'b0, cfg.bin_spacing}));
	assign tc_full  = off_q - TC_W'(item_q.arrival);
	assign tc_pos   = (tc_full > 0);
	assign kext     = {{AW{1'b0}}, k_q};
	assign addr     = kext[AW-1:0];
	assign last_bin = (k_q == item_q.nb - NB_W'(1));
	assign out_free = !ovalid_q || m_axis_tready;
	assign base     = vbit_q ? $signed(rdata) : '0;

	shpba_kernel u_kernel (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (kstart),
		.tc        (tc_full[TC_W-2:0]),
		.mode      (cfg.mode),
		.peak_time (cfg.peak_time),
		.done      (kdone),
		.kval      (kval)
	);

	shpba_ram #(
		.WIDTH (VAL_W),
		.DEPTH (MAX_BINS)
	) u_bins (
		.clk   (clk),
		.we    (ram_we),
		.waddr (addr),
		.wdata (acc_sat),
		.re    (ram_re),
		.raddr (addr),
		.rdata (rdata)
	);

	always_comb begin
		cmag = c_q[56] ? 57'(-c_q) : c_q;
		qs   = c_q[56] ? -$signed({1'b0, cmag[56:8]}) : $signed({1'b0, cmag[56:8]});
		sum  = 51'(base) + 51'(qs);
		if (sum > 51'(MAX48)) begin
			acc_sat = MAX48;
		end else if (sum < 51'(MIN48)) begin
			acc_sat = MIN48;
		end else begin
			acc_sat = sum[VAL_W-1:0];
		end
	end

	always_comb begin
		fac1 = cfg.mode ? {1'b0, cfg.cross_two_sides} : (ONE_Q16 - {1'b0, cfg.cross_two_sides});
		fac2 = ONE_Q16 - {1'b0, cfg.cross_back};
		m2   = 51'(m1_q) * 51'(fac2);
		amag = base[VAL_W-1] ? VAL_W'(-base) : base;
		r    = 49'(ph_q) + 49'(pl_q[47:24]);
		rc   = (r > CAP48) ? CAP48 : r;
		if (neg_q) begin
			oval = VAL_W'(-rc);
		end else if (rc >= CAP48) begin
			oval = MAX48;
		end else begin
			oval = rc[VAL_W-1:0];
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			BS_IDLE:  if (q_valid) state_d = BS_BIN;
			BS_BIN: begin
				if (k_q == item_q.nb) begin
					state_d = item_q.group_end ? BS_NORM1 : BS_IDLE;
				end else if (tc_pos) begin
					state_d = BS_KWAIT;
				end
			end
			BS_KWAIT: if (kdone) state_d = BS_ACC;
			BS_ACC:   state_d = BS_BIN;
			BS_NORM1: state_d = BS_NORM2;
			BS_NORM2: state_d = BS_ERD;
			BS_ERD:   state_d = BS_EMUL;
			BS_EMUL:  state_d = BS_EOUT;
			BS_EOUT:  if (out_free) state_d = last_bin ? BS_IDLE : BS_ERD;
			default:  state_d = BS_IDLE;
		endcase
	end

	always_comb begin
		q_pop  = (state_q == BS_IDLE) && q_valid;
		kstart = (state_q == BS_BIN) && (k_q != item_q.nb) && tc_pos;
		ram_re = kstart || (state_q == BS_ERD);
		ram_we = (state_q == BS_ACC);
		load   = (state_q == BS_EOUT) && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= BS_IDLE;
			vld_q    <= '0;
			ovalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (ram_we) begin
				vld_q[addr] <= 1'b1;
			end
			if (load && last_bin) begin
				vld_q <= '0;
			end
			if (load) begin
				ovalid_q <= 1'b1;
			end else if (m_axis_tready) begin
				ovalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			item_q <= q_item;
			k_q    <= '0;
			off_q  <= TC_W'(q_item.threshold) - sp;
		end
		if (ram_re) begin
			vbit_q <= vld_q[addr];
		end
		if ((state_q == BS_BIN) && (k_q != item_q.nb) && !tc_pos) begin
			k_q   <= k_q + NB_W'(1);
			off_q <= off_q + sp;
		end
		if (state_q == BS_KWAIT && kdone) begin
			c_q <= 57'(item_q.charge) * 57'(kval);
		end
		if (state_q == BS_ACC) begin
			k_q   <= k_q + NB_W'(1);
			off_q <= off_q + sp;
		end
		if (state_q == BS_NORM1) begin
			m1_q <= 34'(cfg.mode ? NORM_NEIGH : NORM_CENTRAL) * 34'(fac1);
		end
		if (state_q == BS_NORM2) begin
			norm_q <= cfg.mode ? m2[48:25] : m2[47:24];
			k_q    <= '0;
		end
		if (state_q == BS_EMUL) begin
			neg_q <= base[VAL_W-1];
			ph_q  <= 48'(amag[47:24]) * 48'(norm_q);
			pl_q  <= 48'(amag[23:0]) * 48'(norm_q);
		end
		if (load) begin
			odata_q <= oval;
			oidx_q  <= k_q[IDX_W-1:0];
			olast_q <= last_bin;
			k_q     <= k_q + NB_W'(1);
		end
	end

	assign m_axis_tvalid = ovalid_q;
	assign m_axis_tdata  = {4'd0, odata_q, oidx_q};
	assign m_axis_tlast  = olast_q;

endmodule

[rtl/core/shaper_pulse_bin_accumulator.sv]
// ----------------------------------------------------------------------------
// Shaper pulse bin accumulator
// Accumulates a CR-RC^3 shaper response of charge packets into time bins.
// ----------------------------------------------------------------------------
// Each charge beat is queued by the front part and then worked by the back
// part bin by bin: a bin whose sample time the charge has not reached is
// skipped in BS_BIN, while a bin it has reached runs the 39-step restoring
// divider that forms x from peak_time, then five kernel steps and the
// read-modify-write of the bin store. A beat with tlast then runs NORM1 and
// NORM2 for the normalization and, per bin in use, a read, a scaling
// multiply and an emission. A two-entry queue takes new beats while the back
// is busy, and a result register holds a bin beat while the sink stalls.
module shaper_pulse_bin_accumulator #(
	parameter int MAX_BINS = 16
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_we,
	input  logic [shpba_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [shpba_pkg::CFG_DATA_W-1:0]      cfg_data,
	input  logic                                  s_axis_tvalid,
	output logic                                  s_axis_tready,
	// charge_amount[23:0], arrival_time[39:24], threshold_time[55:40]
	input  logic [shpba_pkg::TDATA_W-1:0]         s_axis_tdata,
	input  logic                                  s_axis_tlast,
	output logic                                  m_axis_tvalid,
	input  logic                                  m_axis_tready,
	// bin_index[3:0], bin_value[51:4], zero[55:52]
	output logic [shpba_pkg::TDATA_W-1:0]         m_axis_tdata,
	output logic                                  m_axis_tlast
);

	import shpba_pkg::*;

	localparam int QUEUE_DEPTH = 2;

	cfg_t  cfg_q;
	logic  push, full, q_valid, q_pop;
	item_t push_item, q_item;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mode            <= 1'b0;
			cfg_q.peak_time       <= 16'd336;
			cfg_q.num_bins        <= 5'd3;
			cfg_q.bin_spacing     <= 16'd400;
			cfg_q.cross_two_sides <= 16'd0;
			cfg_q.cross_back      <= 16'd0;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_MODE:        cfg_q.mode            <= cfg_data[0];
				REG_PEAK_TIME:   cfg_q.peak_time       <= cfg_data;
				REG_NUM_BINS:    cfg_q.num_bins        <= cfg_data[NB_W-1:0];
				REG_BIN_SPACING: cfg_q.bin_spacing     <= cfg_data;
				REG_CROSS_TWO:   cfg_q.cross_two_sides <= cfg_data;
				REG_CROSS_BACK:  cfg_q.cross_back      <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	shpba_front #(
		.MAX_BINS (MAX_BINS)
	) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.num_bins      (cfg_q.num_bins),
		.push          (push),
		.push_item     (push_item),
		.full          (full)
	);

	shpba_fifo #(
		.WIDTH ($bits(item_t)),
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.din    (push_item),
		.full   (full),
		.pop    (q_pop),
		.dout   (q_item),
		.valid  (q_valid)
	);

	shpba_back #(
		.MAX_BINS (MAX_BINS)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg_q),
		.q_valid       (q_valid),
		.q_item        (q_item),
		.q_pop         (q_pop),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

endmodule

[rtl/core/shpba_checker.sv]
// ----------------------------------------------------------------------------
// Shaper pulse bin accumulator checker
// Port-level checks on bin beat hold under stall, order and group accounting.
// ----------------------------------------------------------------------------
module shpba_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          s_axis_tvalid,
	input logic                          s_axis_tready,
	input logic                          s_axis_tlast,
	input logic                          m_axis_tvalid,
	input logic                          m_axis_tready,
	input logic [shpba_pkg::TDATA_W-1:0] m_axis_tdata,
	input logic                          m_axis_tlast
);

	logic [3:0] exp_idx_q;
	logic [3:0] pend_q;
	logic       in_end, out_end;

	assign in_end  = s_axis_tvalid && s_axis_tready && s_axis_tlast;
	assign out_end = m_axis_tvalid && m_axis_tready && m_axis_tlast;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exp_idx_q <= '0;
			pend_q    <= '0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				exp_idx_q <= m_axis_tlast ? 4'd0 : exp_idx_q + 4'd1;
			end
			if (in_end && !out_end) begin
				pend_q <= pend_q + 4'd1;
			end else if (out_end && !in_end) begin
				pend_q <= pend_q - 4'd1;
			end
		end
	end

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
			m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
		else $error("bin beat changed while stalled");

	a_index: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[3:0] == exp_idx_q)
		else $error("bin index out of sequence");

	a_group: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> pend_q != 4'd0)
		else $error("bin beat without a closed group");

	a_pad: assert property (@(posedge clk) disable iff (!arst_n)
		out_end |=> !m_axis_tvalid || m_axis_tdata[3:0] == 4'd0)
		else $error("group did not restart at bin zero");

endmodule

bind shaper_pulse_bin_accumulator shpba_checker u_shpba_checker (.*);
